/* src/gpf_pkg.sv */
// Shared constants for the glyph path flattener: command codes, fixed field
// widths and default parameter values.
// No dependencies.
package gpf_pkg;

    localparam int REQ_TYPE_W = 2;
    localparam int DELTA_W    = 16;
    localparam int VERT_W     = 32;
    localparam int SEG_CFG_W  = 7;

    localparam logic [SEG_CFG_W-1:0] SEG_RESET = SEG_CFG_W'(10);

    localparam int DEF_MAX_SEGMENTS = 64;
    localparam int DEF_FRAC_BITS    = 8;
    localparam int DEF_COORD_BITS   = 24;

    localparam logic [REQ_TYPE_W-1:0] CMD_MOVE  = 2'd0;
    localparam logic [REQ_TYPE_W-1:0] CMD_LINE  = 2'd1;
    localparam logic [REQ_TYPE_W-1:0] CMD_CURVE = 2'd2;
    localparam logic [REQ_TYPE_W-1:0] CMD_SKIP  = 2'd3;

endpackage

/* src/glyph_path_flattener.sv */
// Glyph path flattener: relative path commands in, absolute fixed point vertices out.
// One shared multiplier under a micro-sequencer, plus a restoring divider.
// Depends on gpf_pkg.
//
// Move and line requests give one vertex each; an ignored command gives none.
// A curve with S segments first forms S squared and S cubed in setup, then for
// each of the S-1 interior points runs the multiplier (weights and both weighted
// sums), two divisions (one quotient bit per cycle, plus load and finish) and an
// output step, then gives the end point. Input is refused while a curve is in
// progress or a vertex waits that is not being taken. The segment count is
// written on its own channel; the user is to write it only at idle moments, and
// the block itself does not enforce this. Zero acts as one and values above
// MAX_SEGMENTS act as MAX_SEGMENTS.
module glyph_path_flattener
    import gpf_pkg::*;
#(
    parameter int MAX_SEGMENTS = DEF_MAX_SEGMENTS,
    parameter int FRAC_BITS    = DEF_FRAC_BITS,
    parameter int COORD_BITS   = DEF_COORD_BITS
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    // cfg_data: segments
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [SEG_CFG_W-1:0]    cfg_data,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    // s_tdata: dx1, dy1, dx2, dy2, dx3, dy3 (16 bits each, lowest first)
    input  logic [6*DELTA_W-1:0]    s_tdata,
    // s_tuser: req_type
    input  logic [REQ_TYPE_W-1:0]   s_tuser,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    // m_tdata: vx, vy (32 bits each, lowest first)
    output logic [2*VERT_W-1:0]     m_tdata,
    // m_tuser: contour_start
    output logic                    m_tuser,
    output logic                    m_tlast
);

    localparam int SEG_W  = $clog2(MAX_SEGMENTS + 1);
    localparam int A_W    = DELTA_W + 2;
    localparam int W_W    = 3 * SEG_W;
    localparam int MUL_W  = (W_W + 1 > A_W) ? W_W + 1 : A_W;
    localparam int PROD_W = W_W + A_W;
    localparam int N_W    = W_W + A_W + 2;
    localparam int D_W    = N_W + FRAC_BITS + 2;
    localparam int Q_W    = FRAC_BITS + A_W;
    localparam int R_W    = W_W + 1;
    localparam int CNT_W  = $clog2(Q_W + 1);
    localparam int OP_W   = 4;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SETUP = 3'd1;
    localparam logic [2:0] ST_WGT   = 3'd2;
    localparam logic [2:0] ST_DLOAD = 3'd3;
    localparam logic [2:0] ST_DIV   = 3'd4;
    localparam logic [2:0] ST_EMIT  = 3'd5;
    localparam logic [2:0] ST_END   = 3'd6;

    localparam logic [SEG_W-1:0] SEG_MAX = SEG_W'(MAX_SEGMENTS);
    localparam logic [SEG_W-1:0] SEG_ONE = SEG_W'(1);
    localparam logic [W_W-1:0]   THREE   = W_W'(3);
    localparam logic [CNT_W-1:0] CNT_ALL = CNT_W'(Q_W);

    // control state
    logic [2:0]                 state_reg, state_next;
    logic [OP_W-1:0]            op_reg, op_next;
    logic [SEG_CFG_W-1:0]       segments_reg, segments_next;
    logic [SEG_W-1:0]           seg_reg, seg_next;
    logic [SEG_W-1:0]           k_reg, k_next;
    logic signed [COORD_BITS-1:0] cur_x_reg, cur_x_next, cur_y_reg, cur_y_next;
    logic                       m_valid_reg, m_valid_next;
    logic                       div_y_reg, div_y_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;

    // datapath
    logic signed [A_W-1:0]      a1x_reg, a1x_next, a1y_reg, a1y_next;
    logic signed [A_W-1:0]      a2x_reg, a2x_next, a2y_reg, a2y_next;
    logic signed [A_W-1:0]      a3x_reg, a3x_next, a3y_reg, a3y_next;
    logic [W_W-1:0]             den_reg, den_next;
    logic [W_W-1:0]             uk_reg, uk_next;
    logic [W_W-1:0]             w1_reg, w1_next, w2_reg, w2_next, w3_reg, w3_next;
    logic signed [N_W-1:0]      acc_reg, acc_next, nx_reg, nx_next, ny_reg, ny_next;
    logic signed [PROD_W-1:0]   prod_reg;
    logic [R_W-1:0]             rem_reg, rem_next;
    logic [Q_W-1:0]             dq_reg, dq_next;
    logic                       neg_reg, neg_next;
    logic signed [Q_W:0]        off_x_reg, off_x_next, off_y_reg, off_y_next;
    logic [2*VERT_W-1:0]        m_data_reg, m_data_next;
    logic                       m_cs_reg, m_cs_next;
    logic                       m_last_reg, m_last_next;

    logic signed [MUL_W-1:0]    mul_a, mul_b;
    logic signed [2*MUL_W-1:0]  mul_full;

    logic                       out_free;
    logic                       in_fire;
    logic signed [DELTA_W-1:0]  d1x, d1y, d2x, d2y, d3x, d3y;
    logic signed [A_W-1:0]      in_a1x, in_a1y, in_a2x, in_a2y;
    logic [SEG_W-1:0]           seg_eff;
    logic [SEG_W-1:0]           u_val;
    logic signed [N_W-1:0]      acc_sum;
    logic signed [N_W-1:0]      n_sel;
    logic signed [D_W-1:0]      dval;
    logic [D_W-1:0]             mag;
    logic [R_W:0]               trial;
    logic                       trial_ge;
    logic [R_W-1:0]             div_q;
    logic signed [Q_W:0]        quot;
    logic signed [Q_W:0]        off_val;
    logic signed [COORD_BITS-1:0] mv_x, mv_y, end_x, end_y;
    logic signed [VERT_W-1:0]   base_x, base_y;

    assign d1x = s_tdata[1*DELTA_W-1 -: DELTA_W];
    assign d1y = s_tdata[2*DELTA_W-1 -: DELTA_W];
    assign d2x = s_tdata[3*DELTA_W-1 -: DELTA_W];
    assign d2y = s_tdata[4*DELTA_W-1 -: DELTA_W];
    assign d3x = s_tdata[5*DELTA_W-1 -: DELTA_W];
    assign d3y = s_tdata[6*DELTA_W-1 -: DELTA_W];

    assign in_a1x = A_W'(d1x);
    assign in_a1y = A_W'(d1y);
    assign in_a2x = in_a1x + A_W'(d2x);
    assign in_a2y = in_a1y + A_W'(d2y);

    assign out_free  = !m_valid_reg || m_tready;
    assign s_tready  = (state_reg == ST_IDLE) && out_free;
    assign in_fire   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_cs_reg;
    assign m_tlast  = m_last_reg;

    always_comb begin
        if (segments_reg == '0) begin
            seg_eff = SEG_ONE;
        end else if (SEG_CFG_W'(segments_reg) > SEG_CFG_W'(MAX_SEGMENTS)) begin
            seg_eff = SEG_MAX;
        end else begin
            seg_eff = SEG_W'(segments_reg);
        end
    end

    assign u_val   = seg_reg - k_reg;
    assign acc_sum = acc_reg + N_W'(prod_reg);

    assign mv_x  = cur_x_reg + COORD_BITS'(d1x);
    assign mv_y  = cur_y_reg + COORD_BITS'(d1y);
    assign end_x = cur_x_reg + COORD_BITS'(a3x_reg);
    assign end_y = cur_y_reg + COORD_BITS'(a3y_reg);
    assign base_x = VERT_W'(cur_x_reg) <<< FRAC_BITS;
    assign base_y = VERT_W'(cur_y_reg) <<< FRAC_BITS;

    // divider front end: rounding bias folded into the dividend
    assign n_sel  = div_y_reg ? ny_reg : nx_reg;
    assign dval   = (D_W'(n_sel) <<< (FRAC_BITS + 1)) + D_W'(den_reg);
    assign mag    = dval[D_W-1] ? D_W'(-dval) : D_W'(dval);
    assign div_q  = {den_reg, 1'b0};
    assign trial  = {rem_reg, dq_reg[Q_W-1]};
    assign trial_ge = trial >= {1'b0, div_q};
    assign quot   = (Q_W+1)'(dq_reg);
    assign off_val = neg_reg ? -(quot + (Q_W+1)'(rem_reg != '0)) : quot;

    // operand selection for the shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        if (state_reg == ST_SETUP) begin
            case (op_reg)
                4'd0: begin
                    mul_a = MUL_W'(seg_reg);
                    mul_b = MUL_W'(seg_reg);
                end
                4'd1: begin
                    mul_a = MUL_W'(prod_reg[W_W-1:0]);
                    mul_b = MUL_W'(seg_reg);
                end
                default: begin
                    mul_a = '0;
                    mul_b = '0;
                end
            endcase
        end else if (state_reg == ST_WGT) begin
            case (op_reg)
                4'd0: begin
                    mul_a = MUL_W'(u_val);
                    mul_b = MUL_W'(k_reg);
                end
                4'd1: begin
                    mul_a = MUL_W'(prod_reg[W_W-1:0]);
                    mul_b = MUL_W'(u_val);
                end
                4'd2: begin
                    mul_a = MUL_W'(uk_reg);
                    mul_b = MUL_W'(k_reg);
                end
                4'd3: begin
                    mul_a = MUL_W'(k_reg);
                    mul_b = MUL_W'(k_reg);
                end
                4'd4: begin
                    mul_a = MUL_W'(prod_reg[W_W-1:0]);
                    mul_b = MUL_W'(k_reg);
                end
                4'd5: begin
                    mul_a = MUL_W'(w1_reg);
                    mul_b = MUL_W'(a1x_reg);
                end
                4'd6: begin
                    mul_a = MUL_W'(w2_reg);
                    mul_b = MUL_W'(a2x_reg);
                end
                4'd7: begin
                    mul_a = MUL_W'(w3_reg);
                    mul_b = MUL_W'(a3x_reg);
                end
                4'd8: begin
                    mul_a = MUL_W'(w1_reg);
                    mul_b = MUL_W'(a1y_reg);
                end
                4'd9: begin
                    mul_a = MUL_W'(w2_reg);
                    mul_b = MUL_W'(a2y_reg);
                end
                4'd10: begin
                    mul_a = MUL_W'(w3_reg);
                    mul_b = MUL_W'(a3y_reg);
                end
                default: begin
                    mul_a = '0;
                    mul_b = '0;
                end
            endcase
        end
    end

    assign mul_full = mul_a * mul_b;

    always_comb begin
        state_next    = state_reg;
        op_next       = op_reg;
        segments_next = segments_reg;
        seg_next      = seg_reg;
        k_next        = k_reg;
        cur_x_next    = cur_x_reg;
        cur_y_next    = cur_y_reg;
        m_valid_next  = m_valid_reg;
        div_y_next    = div_y_reg;
        cnt_next      = cnt_reg;
        a1x_next = a1x_reg;
        a1y_next = a1y_reg;
        a2x_next = a2x_reg;
        a2y_next = a2y_reg;
        a3x_next = a3x_reg;
        a3y_next = a3y_reg;
        den_next = den_reg;
        uk_next  = uk_reg;
        w1_next  = w1_reg;
        w2_next  = w2_reg;
        w3_next  = w3_reg;
        acc_next = acc_reg;
        nx_next  = nx_reg;
        ny_next  = ny_reg;
        rem_next = rem_reg;
        dq_next  = dq_reg;
        neg_next = neg_reg;
        off_x_next  = off_x_reg;
        off_y_next  = off_y_reg;
        m_data_next = m_data_reg;
        m_cs_next   = m_cs_reg;
        m_last_next = m_last_reg;

        if (m_tready) begin
            m_valid_next = 1'b0;
        end
        if (cfg_valid && cfg_ready) begin
            segments_next = cfg_data;
        end

        case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    if (s_tuser == CMD_MOVE || s_tuser == CMD_LINE) begin
                        cur_x_next   = mv_x;
                        cur_y_next   = mv_y;
                        m_valid_next = 1'b1;
                        m_data_next  = {VERT_W'(mv_y) <<< FRAC_BITS,
                                        VERT_W'(mv_x) <<< FRAC_BITS};
                        m_cs_next    = (s_tuser == CMD_MOVE);
                        m_last_next  = 1'b1;
                    end else if (s_tuser == CMD_CURVE) begin
                        a1x_next   = in_a1x;
                        a1y_next   = in_a1y;
                        a2x_next   = in_a2x;
                        a2y_next   = in_a2y;
                        a3x_next   = in_a2x + A_W'(d3x);
                        a3y_next   = in_a2y + A_W'(d3y);
                        seg_next   = seg_eff;
                        op_next    = '0;
                        state_next = ST_SETUP;
                    end
                end
            end
            ST_SETUP: begin
                // S squared, then S cubed
                op_next = op_reg + 1'b1;
                if (op_reg == 4'd2) begin
                    den_next = prod_reg[W_W-1:0];
                    op_next  = '0;
                    k_next   = SEG_ONE;
                    state_next = (seg_reg == SEG_ONE) ? ST_END : ST_WGT;
                end
            end
            ST_WGT: begin
                op_next = op_reg + 1'b1;
                case (op_reg)
                    4'd1: uk_next = prod_reg[W_W-1:0];
                    4'd2: w1_next = prod_reg[W_W-1:0] * THREE;
                    4'd3: w2_next = prod_reg[W_W-1:0] * THREE;
                    4'd5: w3_next = prod_reg[W_W-1:0];
                    4'd6: acc_next = N_W'(prod_reg);
                    4'd7: acc_next = acc_sum;
                    4'd8: nx_next = acc_sum;
                    4'd9: acc_next = N_W'(prod_reg);
                    4'd10: acc_next = acc_sum;
                    4'd11: begin
                        ny_next    = acc_sum;
                        div_y_next = 1'b0;
                        op_next    = '0;
                        state_next = ST_DLOAD;
                    end
                    default: begin
                    end
                endcase
            end
            ST_DLOAD: begin
                neg_next   = dval[D_W-1];
                rem_next   = R_W'(mag >> Q_W);
                dq_next    = mag[Q_W-1:0];
                cnt_next   = CNT_ALL;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (cnt_reg != '0) begin
                    rem_next = trial_ge ? R_W'(trial - {1'b0, div_q}) : R_W'(trial);
                    dq_next  = {dq_reg[Q_W-2:0], trial_ge};
                    cnt_next = cnt_reg - 1'b1;
                end else if (!div_y_reg) begin
                    off_x_next = off_val;
                    div_y_next = 1'b1;
                    state_next = ST_DLOAD;
                end else begin
                    off_y_next = off_val;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {base_y + VERT_W'(off_y_reg), base_x + VERT_W'(off_x_reg)};
                    m_cs_next    = 1'b0;
                    m_last_next  = 1'b0;
                    if (k_reg == seg_reg - SEG_ONE) begin
                        state_next = ST_END;
                    end else begin
                        k_next     = k_reg + SEG_ONE;
                        state_next = ST_WGT;
                    end
                end
            end
            ST_END: begin
                if (out_free) begin
                    cur_x_next   = end_x;
                    cur_y_next   = end_y;
                    m_valid_next = 1'b1;
                    m_data_next  = {VERT_W'(end_y) <<< FRAC_BITS,
                                    VERT_W'(end_x) <<< FRAC_BITS};
                    m_cs_next    = 1'b0;
                    m_last_next  = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            op_reg       <= '0;
            segments_reg <= SEG_RESET;
            seg_reg      <= SEG_ONE;
            k_reg        <= SEG_ONE;
            cur_x_reg    <= '0;
            cur_y_reg    <= '0;
            m_valid_reg  <= 1'b0;
            div_y_reg    <= 1'b0;
            cnt_reg      <= '0;
        end else begin
            state_reg    <= state_next;
            op_reg       <= op_next;
            segments_reg <= segments_next;
            seg_reg      <= seg_next;
            k_reg        <= k_next;
            cur_x_reg    <= cur_x_next;
            cur_y_reg    <= cur_y_next;
            m_valid_reg  <= m_valid_next;
            div_y_reg    <= div_y_next;
            cnt_reg      <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg   <= mul_full[PROD_W-1:0];
        a1x_reg    <= a1x_next;
        a1y_reg    <= a1y_next;
        a2x_reg    <= a2x_next;
        a2y_reg    <= a2y_next;
        a3x_reg    <= a3x_next;
        a3y_reg    <= a3y_next;
        den_reg    <= den_next;
        uk_reg     <= uk_next;
        w1_reg     <= w1_next;
        w2_reg     <= w2_next;
        w3_reg     <= w3_next;
        acc_reg    <= acc_next;
        nx_reg     <= nx_next;
        ny_reg     <= ny_next;
        rem_reg    <= rem_next;
        dq_reg     <= dq_next;
        neg_reg    <= neg_next;
        off_x_reg  <= off_x_next;
        off_y_reg  <= off_y_next;
        m_data_reg <= m_data_next;
        m_cs_reg   <= m_cs_next;
        m_last_reg <= m_last_next;
    end

    // a contour start is always the only vertex of its request
    a_cs_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("contour start vertex without last flag");

    // partial remainder stays below the divisor while iterating
    a_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DIV |-> rem_reg < div_q)
        else $error("divider remainder out of range");

    // interior points only for k between 1 and S-1
    a_k_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_WGT |-> (k_reg != '0 && k_reg < seg_reg))
        else $error("interior point index out of range");

    // a request that produces vertices leaves either a vertex or work in flight
    a_req_progress: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser != CMD_SKIP |=> m_tvalid || state_reg != ST_IDLE)
        else $error("request dropped without output");

endmodule

/* tb/testbench.sv */
// Self-checking bench for glyph_path_flattener: path command requests are streamed in and
// every vertex is checked against a flattening model kept inside the bench.
// Depends on gpf_pkg and the glyph_path_flattener RTL.
module testbench
    import gpf_pkg::*;
();

    localparam int     FRAC        = DEF_FRAC_BITS;
    localparam int     SEG_MAX     = DEF_MAX_SEGMENTS;
    localparam int     PEN_W       = DEF_COORD_BITS;
    localparam int     SETTLE      = 80;
    localparam int     QUIET_LIMIT = 5000;
    localparam longint HOP_MAX     = 98301;
    localparam longint EDGE        = (longint'(1) <<< (PEN_W - 1)) - 40000;

    typedef struct packed {
        logic [REQ_TYPE_W-1:0] kind;
        logic [DELTA_W-1:0]    dx1, dy1, dx2, dy2, dx3, dy3;
    } path_cmd_t;

    typedef struct packed {
        logic [VERT_W-1:0] vx, vy;
        logic              contour_start, last;
    } vertex_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic [SEG_CFG_W-1:0]  cfg_data  = '0;
    logic                  cfg_ready;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [6*DELTA_W-1:0]  s_tdata   = '0;
    logic [REQ_TYPE_W-1:0] s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [2*VERT_W-1:0]   m_tdata;
    logic                  m_tuser;
    logic                  m_tlast;

    path_cmd_t cmd_queue[$];
    vertex_t   vertex_queue[$];
    path_cmd_t cur_cmd;
    bit        took_item = 1'b0;

    // pen position and segment register as the block should hold them
    logic signed [PEN_W-1:0] pen_x = '0;
    logic signed [PEN_W-1:0] pen_y = '0;
    logic [SEG_CFG_W-1:0]    seg_setting = SEG_RESET;

    int gap_pct    = 0;
    int stall_pct  = 0;
    int gap_left   = 0;
    int stall_left = 0;
    int mismatches = 0;

    glyph_path_flattener uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic void queue_cmd(path_cmd_t c);
        cmd_queue = {cmd_queue, c};
    endfunction

    function automatic void queue_vertex(vertex_t v);
        vertex_queue = {vertex_queue, v};
    endfunction

    function automatic longint floor_div(longint num, longint den);
        longint q;
        q = num / den;
        if (num % den < 0) q = q - 1;
        return q;
    endfunction

    function automatic longint sx16(logic [DELTA_W-1:0] v);
        return longint'($signed(v));
    endfunction

    function automatic vertex_t pen_vertex(bit cs);
        vertex_t v;
        v.vx            = VERT_W'(longint'(pen_x) <<< FRAC);
        v.vy            = VERT_W'(longint'(pen_y) <<< FRAC);
        v.contour_start = cs;
        v.last          = 1'b1;
        return v;
    endfunction

    // Advance the pen for one request and queue the vertices it must produce.
    function automatic void flatten_cmd(path_cmd_t c);
        longint  s, den, u, w1, w2, w3, nx, ny, bx, by;
        longint  a1x, a1y, a2x, a2y, a3x, a3y;
        vertex_t v;
        case (c.kind)
            CMD_MOVE, CMD_LINE: begin
                pen_x = PEN_W'(longint'(pen_x) + sx16(c.dx1));
                pen_y = PEN_W'(longint'(pen_y) + sx16(c.dy1));
                queue_vertex(pen_vertex(c.kind == CMD_MOVE));
            end
            CMD_CURVE: begin
                s = longint'(seg_setting);
                if (s < 1) s = 1;
                if (s > SEG_MAX) s = SEG_MAX;
                den = s * s * s;
                a1x = sx16(c.dx1);
                a1y = sx16(c.dy1);
                a2x = a1x + sx16(c.dx2);
                a2y = a1y + sx16(c.dy2);
                a3x = a2x + sx16(c.dx3);
                a3y = a2y + sx16(c.dy3);
                bx  = longint'(pen_x) <<< FRAC;
                by  = longint'(pen_y) <<< FRAC;
                for (longint k = 1; k < s; k++) begin
                    u  = s - k;
                    w1 = 3 * u * u * k;
                    w2 = 3 * u * k * k;
                    w3 = k * k * k;
                    nx = (w1 * a1x + w2 * a2x + w3 * a3x) <<< FRAC;
                    ny = (w1 * a1y + w2 * a2y + w3 * a3y) <<< FRAC;
                    // round half up, and wrap to 32 bits rather than to the pen width
                    v.vx            = VERT_W'(bx + floor_div(2 * nx + den, 2 * den));
                    v.vy            = VERT_W'(by + floor_div(2 * ny + den, 2 * den));
                    v.contour_start = 1'b0;
                    v.last          = 1'b0;
                    queue_vertex(v);
                end
                pen_x = PEN_W'(longint'(pen_x) + a3x);
                pen_y = PEN_W'(longint'(pen_y) + a3y);
                queue_vertex(pen_vertex(1'b0));
            end
            default: ;
        endcase
    endfunction

    function automatic path_cmd_t make_cmd(logic [REQ_TYPE_W-1:0] kind, longint x1, longint y1,
                                           longint x2, longint y2, longint x3, longint y3);
        path_cmd_t c;
        c.kind = kind;
        c.dx1  = DELTA_W'(x1);
        c.dy1  = DELTA_W'(y1);
        c.dx2  = DELTA_W'(x2);
        c.dy2  = DELTA_W'(y2);
        c.dx3  = DELTA_W'(x3);
        c.dy3  = DELTA_W'(y3);
        return c;
    endfunction

    function automatic logic [DELTA_W-1:0] pick_delta(int big_pct);
        int r;
        r = $urandom_range(99);
        if (r < 5) return $urandom_range(1) ? 16'h7fff : 16'h8000;
        if (r < big_pct) return DELTA_W'($urandom);
        return DELTA_W'($urandom_range(512) - 256);
    endfunction

    function automatic path_cmd_t random_cmd(int big_pct);
        path_cmd_t c;
        int        r;
        r      = $urandom_range(99);
        c.kind = (r < 15) ? CMD_MOVE : (r < 45) ? CMD_LINE : (r < 90) ? CMD_CURVE : CMD_SKIP;
        c.dx1  = pick_delta(big_pct);
        c.dy1  = pick_delta(big_pct);
        c.dx2  = pick_delta(big_pct);
        c.dy2  = pick_delta(big_pct);
        c.dx3  = pick_delta(big_pct);
        c.dy3  = pick_delta(big_pct);
        return c;
    endfunction

    // Hold until every request has gone in and every vertex has come out, then let
    // the block finish any ignored request.
    task automatic wait_quiet();
        while (cmd_queue.size() != 0 || s_tvalid || vertex_queue.size() != 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_segments(int value);
        wait_quiet();
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= SEG_CFG_W'(value);
        do @(posedge aclk); while (!cfg_ready);
        seg_setting = SEG_CFG_W'(value);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(int seg, int count, int gap, int stall, int big_pct);
        path_cmd_t c;
        int        n;
        write_segments(seg);
        gap_pct   = gap;
        stall_pct = stall;
        n = 0;
        while (n < count) begin
            c = random_cmd(big_pct);
            queue_cmd(c);
            if (c.kind != CMD_SKIP) n++;
        end
    endtask

    // Walk the pen with single-segment curves to just short of the wrap point.
    task automatic ramp_to_edge();
        longint tx, ty, hx, hy;
        tx = longint'(pen_x);
        ty = longint'(pen_y);
        while (tx != EDGE || ty != -EDGE) begin
            hx = EDGE - tx;
            hy = -EDGE - ty;
            if (hx > HOP_MAX) hx = HOP_MAX;
            if (hx < -HOP_MAX) hx = -HOP_MAX;
            if (hy > HOP_MAX) hy = HOP_MAX;
            if (hy < -HOP_MAX) hy = -HOP_MAX;
            queue_cmd(make_cmd(CMD_CURVE, hx / 3, hy / 3, hx / 3, hy / 3,
                               hx - 2 * (hx / 3), hy - 2 * (hy / 3)));
            tx = tx + hx;
            ty = ty + hy;
        end
    endtask

    // request sender
    always @(posedge aclk) begin : take_cmd
        took_item = aresetn && s_tvalid && s_tready;
        if (took_item) flatten_cmd(cur_cmd);
    end

    always @(negedge aclk) begin : drive_cmd
        logic next_valid;
        next_valid = s_tvalid && !took_item;
        if (aresetn && !next_valid) begin
            if (gap_left > 0) begin
                gap_left--;
            end else if (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
                gap_left = $urandom_range(13);
            end else if (cmd_queue.size() > 0) begin
                cur_cmd = cmd_queue.pop_front();
                s_tdata <= {cur_cmd.dy3, cur_cmd.dx3, cur_cmd.dy2, cur_cmd.dx2,
                            cur_cmd.dy1, cur_cmd.dx1};
                s_tuser <= cur_cmd.kind;
                next_valid = 1'b1;
            end
        end
        s_tvalid <= next_valid;
    end

    // vertex receiver
    always @(negedge aclk) begin : drive_ready
        if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if (stall_pct > 0 && $urandom_range(99) < stall_pct) begin
            stall_left = $urandom_range(13);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin : check_vertex
        vertex_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (vertex_queue.size() == 0) begin
                $error("unexpected vertex: vx=%h vy=%h", m_tdata[VERT_W-1:0],
                       m_tdata[2*VERT_W-1:VERT_W]);
                mismatches++;
            end else begin
                want = vertex_queue.pop_front();
                if (m_tdata[VERT_W-1:0] !== want.vx) begin
                    $error("vx: expected %h, got %h", want.vx, m_tdata[VERT_W-1:0]);
                    mismatches++;
                end
                if (m_tdata[2*VERT_W-1:VERT_W] !== want.vy) begin
                    $error("vy: expected %h, got %h", want.vy, m_tdata[2*VERT_W-1:VERT_W]);
                    mismatches++;
                end
                if (m_tuser !== want.contour_start) begin
                    $error("contour_start: expected %b, got %b", want.contour_start, m_tuser);
                    mismatches++;
                end
                if (m_tlast !== want.last) begin
                    $error("last: expected %b, got %b", want.last, m_tlast);
                    mismatches++;
                end
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb: failure");
        $finish;
    end

    initial begin : stimulus
        gap_pct   = 15;
        stall_pct = 10;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset segment count first: extremes, ignored requests, flat and small curves
        queue_cmd(make_cmd(CMD_MOVE, 0, 0, 0, 0, 0, 0));
        queue_cmd(make_cmd(CMD_MOVE, 32767, -32768, -1, -1, -1, -1));
        queue_cmd(make_cmd(CMD_LINE, -32768, 32767, 0, 0, 0, 0));
        queue_cmd(make_cmd(CMD_LINE, -1, 1, 32767, -32768, 5, 5));
        queue_cmd(make_cmd(CMD_SKIP, -1, -1, -1, -1, -1, -1));
        queue_cmd(make_cmd(CMD_SKIP, 0, 0, 0, 0, 0, 0));
        queue_cmd(make_cmd(CMD_CURVE, 0, 0, 0, 0, 0, 0));
        queue_cmd(make_cmd(CMD_CURVE, 32767, 32767, 32767, 32767, 32767, 32767));
        queue_cmd(make_cmd(CMD_CURVE, -32768, -32768, -32768, -32768, -32768, -32768));
        queue_cmd(make_cmd(CMD_CURVE, 32767, -32768, -32768, 32767, 32767, -32768));
        queue_cmd(make_cmd(CMD_CURVE, 3, -5, 7, 1, -2, 9));
        queue_cmd(make_cmd(CMD_MOVE, 100, -100, 0, 0, 0, 0));
        queue_cmd(make_cmd(CMD_CURVE, 1, -1, 1, -1, 1, -1));

        // zero acts as one segment
        write_segments(0);
        queue_cmd(make_cmd(CMD_CURVE, 1000, -1000, 2000, 3, -7, 11));
        queue_cmd(make_cmd(CMD_CURVE, -32768, 32767, -32768, 32767, -32768, 32767));
        queue_cmd(make_cmd(CMD_LINE, 5, 5, 0, 0, 0, 0));
        write_segments(1);
        queue_cmd(make_cmd(CMD_CURVE, -20000, 123, 456, -789, 32767, -1));
        queue_cmd(make_cmd(CMD_CURVE, 7, 7, -7, -7, 7, 7));
        // above the maximum saturates; small deltas give rounding ties
        write_segments(127);
        queue_cmd(make_cmd(CMD_CURVE, 1, -1, 0, 1, -1, 0));
        queue_cmd(make_cmd(CMD_CURVE, 300, -200, -100, 50, 7, -3));

        run_phase(3, 40, 20, 10, 50);
        run_phase(64, 6, 10, 10, 50);

        // carry the pen across the wrap point in both axes
        write_segments(1);
        ramp_to_edge();
        write_segments(6);
        for (int i = 0; i < 10; i++)
            queue_cmd(make_cmd(CMD_CURVE,
                $urandom_range(20000, 32767), -longint'($urandom_range(20000, 32768)),
                $urandom_range(20000, 32767), -longint'($urandom_range(20000, 32768)),
                $urandom_range(20000, 32767), -longint'($urandom_range(20000, 32768))));

        run_phase(2, 40, 20, 20, 60);
        run_phase(16, 30, 0, 0, 40);
        run_phase($urandom_range(4, 12), 50, 25, 8, 50);
        run_phase(5, 30, 30, 20, 30);
        run_phase(7, 50, 0, 0, 50);

        wait_quiet();
        if (vertex_queue.size() != 0) begin
            $error("%0d vertices never arrived", vertex_queue.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

/* files.f */
src/gpf_pkg.sv
src/glyph_path_flattener.sv
tb/testbench.sv
